>>> rtl/quadratic_root_solver_unit_macros.svh
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define QRS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quadratic root solver: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quadratic root solver: next-cycle check failed");

`endif

>>> rtl/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
package qrs_pkg;

  localparam int unsigned ROOT_WIDTH = 34;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_TWO    = 2'd2,
    ST_DEGEN  = 2'd3
  } root_status_e;

endpackage

>>> rtl/qrs_req_if.sv
// Request channel: one coefficient set per transfer.
interface qrs_req_if #(
  parameter int unsigned COEF_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

>>> rtl/qrs_res_if.sv
// Result channel: classification and both roots.
interface qrs_res_if;
  import qrs_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   root_status;
  logic signed [ROOT_WIDTH-1:0] root_plus;
  logic signed [ROOT_WIDTH-1:0] root_minus;
  logic                         plus_is_whole;
  logic                         minus_is_whole;

  modport source (output valid, root_status, root_plus, root_minus, plus_is_whole,
                  minus_is_whole, input ready);
  modport sink   (input valid, root_status, root_plus, root_minus, plus_is_whole,
                  minus_is_whole, output ready);
endinterface

>>> rtl/qrs_disc.sv
// Two-stage discriminant and classification front end.
module qrs_disc #(
  parameter int unsigned COEF_WIDTH = 16,
  localparam int unsigned DW = 2 * COEF_WIDTH + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         vld_i,
  input  logic signed [COEF_WIDTH-1:0] a_i,
  input  logic signed [COEF_WIDTH-1:0] b_i,
  input  logic signed [COEF_WIDTH-1:0] c_i,
  output logic                         vld_o,
  output logic [DW-1:0]                disc_o,
  output qrs_pkg::root_status_e        status_o,
  output logic signed [COEF_WIDTH-1:0] a_o,
  output logic signed [COEF_WIDTH-1:0] b_o
);
  import qrs_pkg::*;

  localparam int unsigned PW = 2 * COEF_WIDTH;

  logic                         v1_q, v2_q;
  logic signed [PW-1:0]         bb_d, ac_d, bb_q, ac_q;
  logic signed [COEF_WIDTH-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [DW:0]           disc;
  root_status_e                 st_d, st_q;
  logic [DW-1:0]                disc_d, disc_q;

  assign bb_d = b_i * b_i;
  assign ac_d = a_i * c_i;

  always_comb begin
    disc = {{2{bb_q[PW-1]}}, bb_q} - {ac_q, 2'b00};
    if (a1_q == '0) begin
      st_d = ST_DEGEN;
    end else if (disc[DW]) begin
      st_d = ST_NONE;
    end else if (disc == '0) begin
      st_d = ST_DOUBLE;
    end else begin
      st_d = ST_TWO;
    end
    disc_d = disc[DW] ? '0 : disc[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bb_q   <= bb_d;
      ac_q   <= ac_d;
      a1_q   <= a_i;
      b1_q   <= b_i;
      disc_q <= disc_d;
      st_q   <= st_d;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
    end
  end

  assign vld_o    = v2_q;
  assign disc_o   = disc_q;
  assign status_o = st_q;
  assign a_o      = a2_q;
  assign b_o      = b2_q;
endmodule

>>> rtl/qrs_sqrt.sv
// Pipelined digit-by-digit floor square root of d scaled by 2^(2*FRAC_BITS).
module qrs_sqrt #(
  parameter int unsigned D_WIDTH    = 33,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned SIDE_WIDTH = 2,
  localparam int unsigned NI = (D_WIDTH + 1) / 2 + FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  vld_i,
  input  logic [D_WIDTH-1:0]    d_i,
  input  logic [SIDE_WIDTH-1:0] side_i,
  output logic                  vld_o,
  output logic [NI-1:0]         root_o,
  output logic [SIDE_WIDTH-1:0] side_o
);
  localparam int unsigned PW = 2 * NI;

  logic                  vld_q  [NI];
  logic [PW-1:0]         x_q    [NI];
  logic [NI+1:0]         rem_q  [NI];
  logic [NI-1:0]         root_q [NI];
  logic [SIDE_WIDTH-1:0] side_q [NI];
  logic [PW-1:0]         x0;

  assign x0 = {{(PW - D_WIDTH){1'b0}}, d_i} << (2 * FRAC_BITS);

  for (genvar s = 0; s < NI; s++) begin : g_st
    logic                  vld_in;
    logic [PW-1:0]         x_in;
    logic [NI+1:0]         rem_in;
    logic [NI-1:0]         root_in;
    logic [SIDE_WIDTH-1:0] side_in;
    logic [NI+1:0]         r, trial;
    logic                  ge;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign x_in    = x0;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      r     = {rem_in[NI-1:0], x_in[PW-1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = (r >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[s]    <= x_in << 2;
        rem_q[s]  <= ge ? (r - trial) : r;
        root_q[s] <= {root_in[NI-2:0], ge};
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NI-1];
  assign root_o = root_q[NI-1];
  assign side_o = side_q[NI-1];
endmodule

>>> rtl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
module qrs_div #(
  parameter int unsigned N_WIDTH    = 34,
  parameter int unsigned M_WIDTH    = 17,
  parameter int unsigned SIDE_WIDTH = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  vld_i,
  input  logic [N_WIDTH-1:0]    n_i,
  input  logic [M_WIDTH-1:0]    m_i,
  input  logic [SIDE_WIDTH-1:0] side_i,
  output logic                  vld_o,
  output logic [N_WIDTH-1:0]    q_o,
  output logic [SIDE_WIDTH-1:0] side_o
);
  logic                  vld_q  [N_WIDTH];
  logic [N_WIDTH-1:0]    nq_q   [N_WIDTH];
  logic [M_WIDTH-1:0]    rem_q  [N_WIDTH];
  logic [M_WIDTH-1:0]    m_q    [N_WIDTH];
  logic [SIDE_WIDTH-1:0] side_q [N_WIDTH];

  for (genvar s = 0; s < N_WIDTH; s++) begin : g_st
    logic                  vld_in;
    logic [N_WIDTH-1:0]    nq_in;
    logic [M_WIDTH-1:0]    rem_in, m_in;
    logic [SIDE_WIDTH-1:0] side_in;
    logic [M_WIDTH:0]      r, diff;
    logic                  ge;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign nq_in   = n_i;
      assign rem_in  = '0;
      assign m_in    = m_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign nq_in   = nq_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign m_in    = m_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      r    = {rem_in, nq_in[N_WIDTH-1]};
      diff = r - {1'b0, m_in};
      ge   = (r >= {1'b0, m_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        nq_q[s]   <= {nq_in[N_WIDTH-2:0], ge};
        rem_q[s]  <= ge ? diff[M_WIDTH-1:0] : r[M_WIDTH-1:0];
        m_q[s]    <= m_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[N_WIDTH-1];
  assign q_o    = nq_q[N_WIDTH-1];
  assign side_o = side_q[N_WIDTH-1];
endmodule

>>> rtl/quadratic_root_solver_unit.sv
// Top level of the pipelined quadratic root solver.
//
// Solves a*x^2 + b*x + c = 0 for one coefficient set per request and returns
// the classification and both roots in signed fixed point with FRAC_BITS
// fraction bits. The discriminant is exact; the square root is the floor root
// of D * 2^(2*FRAC_BITS) and the division by 2a truncates toward zero. When a
// is zero the status reads degenerate and the roots and flags are zero; with
// a negative discriminant the roots and flags are zero as well. A new request
// is taken every cycle while the result channel does not stall. The pipeline
// holds a multiply stage and a subtract stage, one square root
// stage per root bit (COEF_WIDTH + FRAC_BITS + 1), a register that forms the
// numerators, one divider stage per numerator magnitude bit
// (COEF_WIDTH + FRAC_BITS + 2) and the output register. Back-pressure on the
// result channel freezes the whole pipeline in place, so ready on the request
// side follows the output register being free or being drained.
`include "quadratic_root_solver_unit_macros.svh"
module quadratic_root_solver_unit #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qrs_req_if.sink   req_i,
  qrs_res_if.source res_o
);
  import qrs_pkg::*;

  localparam int unsigned W  = COEF_WIDTH;
  localparam int unsigned DW = 2 * W + 1;
  localparam int unsigned NI = (DW + 1) / 2 + FRAC_BITS;
  localparam int unsigned NW = W + FRAC_BITS + 3;
  localparam int unsigned MW = W + 1;
  localparam int unsigned SW = 2 + 2 * W;
  localparam int unsigned QX = (NW + 1 > ROOT_WIDTH + 1) ? NW + 1 : ROOT_WIDTH + 1;
  localparam logic signed [QX-1:0] RMAX = (QX'(1) <<< (ROOT_WIDTH - 1)) - QX'(1);
  localparam logic signed [QX-1:0] RMIN = -(QX'(1) <<< (ROOT_WIDTH - 1));

  // advance every stage when the output register is free or being taken
  logic adv;
  logic out_vld_q;
  assign adv         = !out_vld_q || res_o.ready;
  assign req_i.ready = adv;

  // discriminant front end
  logic                d_vld;
  logic [DW-1:0]       d_disc;
  root_status_e        d_st;
  logic signed [W-1:0] d_a, d_b;

  qrs_disc #(.COEF_WIDTH(W)) u_disc (
    .clk_i, .rst_ni, .adv_i(adv),
    .vld_i(req_i.valid && req_i.ready),
    .a_i(req_i.coef_a), .b_i(req_i.coef_b), .c_i(req_i.coef_c),
    .vld_o(d_vld), .disc_o(d_disc), .status_o(d_st), .a_o(d_a), .b_o(d_b)
  );

  // square root, carrying status and coefficients alongside
  logic          s_vld;
  logic [NI-1:0] s_root;
  logic [SW-1:0] s_side;

  qrs_sqrt #(.D_WIDTH(DW), .FRAC_BITS(FRAC_BITS), .SIDE_WIDTH(SW)) u_sqrt (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(d_vld), .d_i(d_disc),
    .side_i({d_st, d_a, d_b}), .vld_o(s_vld), .root_o(s_root), .side_o(s_side)
  );

  // form -b*2^F +/- sqrt(D), split into sign and magnitude, and |2a|
  logic signed [W-1:0]  s_a, s_b;
  logic [1:0]           s_st;
  logic signed [NW-1:0] nb, num_p, num_m, mag_p, mag_m;
  logic signed [W:0]    ax, amag;
  logic                 n_vld_q, n_sp_q, n_sm_q;
  logic [NW-2:0]        n_mp_q, n_mm_q;
  logic [MW-1:0]        n_m_q;
  logic [1:0]           n_st_q;

  always_comb begin
    {s_st, s_a, s_b} = s_side;
    nb    = -(NW'(s_b) <<< FRAC_BITS);
    num_p = nb + NW'(s_root);
    num_m = nb - NW'(s_root);
    mag_p = num_p[NW-1] ? -num_p : num_p;
    mag_m = num_m[NW-1] ? -num_m : num_m;
    ax    = {s_a[W-1], s_a};
    amag  = ax[W] ? -ax : ax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (adv) begin
      n_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_mp_q <= mag_p[NW-2:0];
      n_mm_q <= mag_m[NW-2:0];
      n_sp_q <= num_p[NW-1] ^ s_a[W-1];
      n_sm_q <= num_m[NW-1] ^ s_a[W-1];
      n_m_q  <= {amag[W-2:0], 1'b0} | {amag[W-1], {(MW-1){1'b0}}};
      n_st_q <= s_st;
    end
  end

  // two matched dividers; status rides with the plus root
  logic            dp_vld, dm_vld, q_sp, q_sm;
  logic [NW-2:0]   q_p, q_m;
  logic [1:0]      q_st;

  qrs_div #(.N_WIDTH(NW - 1), .M_WIDTH(MW), .SIDE_WIDTH(3)) u_div_plus (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(n_vld_q), .n_i(n_mp_q), .m_i(n_m_q),
    .side_i({n_st_q, n_sp_q}), .vld_o(dp_vld), .q_o(q_p), .side_o({q_st, q_sp})
  );

  qrs_div #(.N_WIDTH(NW - 1), .M_WIDTH(MW), .SIDE_WIDTH(1)) u_div_minus (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(n_vld_q), .n_i(n_mm_q), .m_i(n_m_q),
    .side_i(n_sm_q), .vld_o(dm_vld), .q_o(q_m), .side_o(q_sm)
  );

  // apply sign, saturate, drop roots that do not exist
  logic signed [QX-1:0]         qx_p, qx_m;
  logic signed [ROOT_WIDTH-1:0] rp_d, rm_d, rp_q, rm_q;
  logic                         real_roots, wp_d, wm_d, wp_q, wm_q;
  root_status_e                 st_e;
  logic [1:0]                   st_q;

  always_comb begin
    st_e       = root_status_e'(q_st);
    real_roots = (st_e == ST_DOUBLE) || (st_e == ST_TWO);
    qx_p = q_sp ? -QX'(q_p) : QX'(q_p);
    qx_m = q_sm ? -QX'(q_m) : QX'(q_m);
    if (qx_p > RMAX) begin
      qx_p = RMAX;
    end else if (qx_p < RMIN) begin
      qx_p = RMIN;
    end
    if (qx_m > RMAX) begin
      qx_m = RMAX;
    end else if (qx_m < RMIN) begin
      qx_m = RMIN;
    end
    rp_d = real_roots ? qx_p[ROOT_WIDTH-1:0] : '0;
    rm_d = real_roots ? qx_m[ROOT_WIDTH-1:0] : '0;
    wp_d = real_roots && (qx_p[FRAC_BITS-1:0] == '0);
    wm_d = real_roots && (qx_m[FRAC_BITS-1:0] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dp_vld && dm_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rp_q <= rp_d;
      rm_q <= rm_d;
      wp_q <= wp_d;
      wm_q <= wm_d;
      st_q <= q_st;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.root_status    = st_q;
  assign res_o.root_plus      = rp_q;
  assign res_o.root_minus     = rm_q;
  assign res_o.plus_is_whole  = wp_q;
  assign res_o.minus_is_whole = wm_q;

  `QRS_ASSERT_IMPLIES(a_degen_zero, res_o.valid && (st_q == ST_DEGEN || st_q == ST_NONE), rp_q == '0 && rm_q == '0 && !wp_q && !wm_q)
  `QRS_ASSERT_IMPLIES(a_double_same, res_o.valid && st_q == ST_DOUBLE, rp_q == rm_q && wp_q == wm_q)
  `QRS_ASSERT_IMPLIES(a_div_lockstep, dp_vld != dm_vld, 1'b0)
  `QRS_ASSERT_NEXT(a_stall_hold, out_vld_q && !res_o.ready, out_vld_q && $stable(rp_q) && $stable(st_q))
endmodule

>>> test/qrs_root_checker.sv
// Result checker of the quadratic root solver: predicts and compares every result.
module qrs_root_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  qrs_req_if    req_mon,
  qrs_res_if    res_mon,
  output int    fail_cnt_o,
  output int    pending_o
);
  import qrs_pkg::*;

  localparam int unsigned FRAC  = 16;
  localparam longint      R_MAX = (64'sd1 <<< (ROOT_WIDTH - 1)) - 1;
  localparam longint      R_MIN = -(64'sd1 <<< (ROOT_WIDTH - 1));

  typedef struct packed {
    root_status_e                 status;
    logic signed [ROOT_WIDTH-1:0] plus;
    logic signed [ROOT_WIDTH-1:0] minus;
    logic                         plus_whole;
    logic                         minus_whole;
  } roots_t;

  roots_t roots_q[$];
  int     mismatches;

  function automatic logic [63:0] floor_root(logic [127:0] rad);
    logic [127:0] acc;
    logic [127:0] trial;
    acc = '0;
    for (int k = 47; k >= 0; k--) begin
      trial = acc | (128'd1 << k);
      if (trial * trial <= rad) acc = trial;
    end
    return acc[63:0];
  endfunction

  function automatic longint clamp_root(longint v);
    if (v > R_MAX) return R_MAX;
    if (v < R_MIN) return R_MIN;
    return v;
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] a, logic signed [15:0] b,
                                         logic signed [15:0] c);
    roots_t r;
    longint disc;
    longint s;
    longint neg_b;
    longint den;
    longint rp;
    longint rm;
    r = '0;
    if (a == 0) begin
      r.status = ST_DEGEN;
      return r;
    end
    disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
    if (disc < 0) begin
      r.status = ST_NONE;
      return r;
    end
    r.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
    s     = longint'(floor_root({64'd0, disc} << (2 * FRAC)));
    neg_b = -longint'(b) * (64'sd1 <<< FRAC);
    den   = 2 * longint'(a);
    rp    = clamp_root((neg_b + s) / den);
    rm    = clamp_root((neg_b - s) / den);
    r.plus        = rp[ROOT_WIDTH-1:0];
    r.minus       = rm[ROOT_WIDTH-1:0];
    r.plus_whole  = (rp[FRAC-1:0] == '0);
    r.minus_whole = (rm[FRAC-1:0] == '0);
    return r;
  endfunction

  function automatic void note_fail(string what, roots_t exp_r, roots_t got_r);
    fail_cnt_o++;
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected st=%0d p=%0d m=%0d pw=%0b mw=%0b, got st=%0d p=%0d m=%0d pw=%0b mw=%0b",
               what, exp_r.status, exp_r.plus, exp_r.minus, exp_r.plus_whole, exp_r.minus_whole,
               got_r.status, got_r.plus, got_r.minus, got_r.plus_whole, got_r.minus_whole);
  endfunction

  always @(posedge clk_i) begin
    roots_t got_r;
    roots_t exp_r;
    if (rst_ni) begin
      // Compare the result first, then log the new request.
      if (res_mon.valid && res_mon.ready) begin
        got_r.status      = root_status_e'(res_mon.root_status);
        got_r.plus        = res_mon.root_plus;
        got_r.minus       = res_mon.root_minus;
        got_r.plus_whole  = res_mon.plus_is_whole;
        got_r.minus_whole = res_mon.minus_is_whole;
        if (roots_q.size() == 0) begin
          note_fail("unexpected result", '0, got_r);
        end else begin
          exp_r = roots_q.pop_front();
          if (got_r.status != exp_r.status)           note_fail("status", exp_r, got_r);
          else if (got_r.plus != exp_r.plus)          note_fail("root_plus", exp_r, got_r);
          else if (got_r.minus != exp_r.minus)        note_fail("root_minus", exp_r, got_r);
          else if (got_r.plus_whole != exp_r.plus_whole)
            note_fail("plus_is_whole", exp_r, got_r);
          else if (got_r.minus_whole != exp_r.minus_whole)
            note_fail("minus_is_whole", exp_r, got_r);
        end
      end
      if (req_mon.valid && req_mon.ready)
        roots_q.push_back(solve_roots(req_mon.coef_a, req_mon.coef_b, req_mon.coef_c));
      pending_o = roots_q.size();
    end
  end
endmodule

>>> test/testbench.sv
// Top of the quadratic root solver testbench: stimulus, clock, reset and verdict.
module testbench;
  import qrs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   cycle_cnt;
  int   req_cnt;
  int   double_cnt;
  int   degen_cnt;

  qrs_req_if req_if ();
  qrs_res_if res_if ();

  quadratic_root_solver_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  qrs_root_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .res_mon    (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the pipeline hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  // Result back-pressure: stall with a chance of about 14 percent, never within a long window.
  always @(negedge clk_i) begin
    if (!rst_ni)
      res_if.ready <= 1'b0;
    else if (cycle_cnt > 2000 && cycle_cnt < 3500)
      res_if.ready <= 1'b1;
    else
      res_if.ready <= ($urandom_range(99) >= 14);
  end

  // Send one request and hold it until the handshake completes; valid stays high
  // for the next request unless an idle cycle drops it.
  task automatic send_req(logic signed [15:0] a, logic signed [15:0] b,
                          logic signed [15:0] c, bit allow_idle);
    logic taken;
    if (allow_idle) begin
      while ($urandom_range(99) < 14) begin
        req_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    req_if.valid  <= 1'b1;
    req_if.coef_a <= a;
    req_if.coef_b <= b;
    req_if.coef_c <= c;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = req_if.ready;
    end
    if (a == 0) degen_cnt++;
    else if (longint'(b) * b == 4 * longint'(a) * c) double_cnt++;
    req_cnt++;
    @(negedge clk_i);
  endtask

  // Random coefficient set: wide values, small values, a forced double root or integer roots.
  task automatic send_random(bit allow_idle);
    int kind;
    int a;
    int r;
    kind = $urandom_range(9);
    if (kind < 4) begin
      send_req(16'($urandom), 16'($urandom), 16'($urandom), allow_idle);
    end else if (kind < 7) begin
      send_req(16'($urandom_range(40) - 20), 16'($urandom_range(80) - 40),
               16'($urandom_range(80) - 40), allow_idle);
    end else if (kind < 9) begin
      // Build (a)(x - r)^2 so the discriminant is exactly zero.
      a = $urandom_range(60) - 30;
      r = $urandom_range(30) - 15;
      send_req(16'(a), 16'(-2 * a * r), 16'(a * r * r), allow_idle);
    end else begin
      // Integer roots p and q: a=1, b=-(p+q), c=p*q.
      a = $urandom_range(200) - 100;
      r = $urandom_range(200) - 100;
      send_req(16'sd1, 16'(-(a + r)), 16'(a * r), allow_idle);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.coef_a = '0;
    req_if.coef_b = '0;
    req_if.coef_c = '0;
    req_cnt    = 0;
    double_cnt = 0;
    degen_cnt  = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: degenerate, sign extremes, double roots, no real root, fractions.
    send_req(16'sd0, 16'sd5, -16'sd3, 1'b1);
    send_req(16'sd0, -16'sd32768, 16'sd32767, 1'b1);
    send_req(16'sd1, -16'sd3, 16'sd2, 1'b1);
    send_req(16'sd1, 16'sd2, 16'sd1, 1'b1);
    send_req(16'sd16384, -16'sd32768, 16'sd16384, 1'b1);
    send_req(-16'sd32768, 16'sd0, 16'sd0, 1'b1);
    send_req(16'sd1, 16'sd0, 16'sd1, 1'b1);
    send_req(16'sd32767, 16'sd0, 16'sd32767, 1'b1);
    send_req(-16'sd32768, 16'sd0, 16'sd32767, 1'b1);
    send_req(-16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_req(16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    send_req(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    send_req(16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_req(16'sd1, -16'sd32768, -16'sd32768, 1'b1);
    send_req(-16'sd1, 16'sd32767, 16'sd32767, 1'b1);
    send_req(16'sd2, 16'sd3, -16'sd7, 1'b1);
    send_req(-16'sd3, 16'sd1, 16'sd5, 1'b1);
    send_req(16'sd3, 16'sd0, -16'sd1, 1'b1);
    send_req(-16'sd1, 16'sd0, 16'sd0, 1'b1);

    // Random, with a stretch free of sender idling and one full drain.
    for (int i = 0; i < 550; i++) begin
      if (i == 300) begin
        req_if.valid <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
      end
      send_random(!(i >= 150 && i < 300));
    end

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (80) @(negedge clk_i);

    $display("sent %0d coefficient sets (%0d with a zero, %0d double roots)",
             req_cnt, degen_cnt, double_cnt);
    $display("with random stalls on both channels and one full pipeline drain");
    if (fail_cnt == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
